/* rtl/ble_wcp_pkg.sv */
// ----------------------------------------------------------------------------
// ble_wcp_pkg
// Types, constants and helper functions shared by the lamp packet encoder.
// ----------------------------------------------------------------------------
package ble_wcp_pkg;

	localparam int MSG_LEN     = 25;
	localparam int PKT_LEN     = 32;
	localparam int HDR_LEN     = 6;
	localparam int MSG_OFS     = HDR_LEN;
	localparam int TRAILER_POS = PKT_LEN - 1;
	localparam int WORD_BYTES  = 8;
	localparam int NUM_WORDS   = PKT_LEN / WORD_BYTES;

	// message byte positions
	localparam int MSG_CMD     = 11;
	localparam int MSG_HOST_HI = 12;
	localparam int MSG_HOST_LO = 13;
	localparam int MSG_ARG1    = 14;
	localparam int MSG_ARG2    = 15;
	localparam int MSG_NONCE   = 17;
	localparam int MSG_CRC_HI  = 23;
	localparam int MSG_CRC_LO  = 24;

	localparam int CRC_FIRST = 11;
	localparam int CRC_LEN   = 12;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam int          WHITEN_SKIP = 13;
	localparam logic [7:0]  WHITEN_SEED = 8'd83;

	localparam logic [7:0]  PKT_TRAILER = 8'h00;

	// configuration port
	localparam int          ADDR_W          = 3;
	localparam int          DATA_W          = 32;
	localparam int          GROUP_W         = 4;
	localparam logic        REG_IDX_GROUP   = 1'b0;
	localparam logic [GROUP_W-1:0] GRP_NIB_RESET = 4'd1;

	typedef logic [7:0] msg_t [MSG_LEN];
	typedef logic [7:0] pkt_t [PKT_LEN];
	typedef logic [7:0] hdr_t [HDR_LEN];

	localparam msg_t MSG_TEMPLATE = '{
		8'h71, 8'h0F, 8'h55, 8'hAA, 8'h98, 8'h43, 8'hAF, 8'h0B,
		8'h46, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h83, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

	localparam hdr_t PKT_HEADER = '{8'h1F, 8'h02, 8'h01, 8'h01, 8'h1B, 8'h03};

	// header bytes 0..5 as they appear in the top of the first packet word
	localparam logic [47:0] PKT_HEADER_BITS = 48'h1F02_0101_1B03;

	// one CRC-16/CCITT byte update, MSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] reverse8(input logic [7:0] v);
		logic [7:0] r;
		for (int b = 0; b < 8; b++) begin
			r[7-b] = v[b];
		end
		return r;
	endfunction

	// one step of the 7-bit whitening LFSR
	function automatic logic [7:0] lfsr_next(input logic [7:0] st);
		logic       fb;
		logic [7:0] rot;
		fb     = st[6];
		rot    = {st[6:0], fb};
		rot[4] = rot[4] ^ fb;
		return rot;
	endfunction

	// whitening byte for message position idx, first stream bit in bit 0
	function automatic logic [7:0] whiten_byte(input int idx);
		logic [7:0] st;
		logic [7:0] m;
		st = WHITEN_SEED;
		m  = '0;
		for (int i = 0; i < (WHITEN_SKIP + idx) * 8; i++) begin
			st = lfsr_next(st);
		end
		for (int b = 0; b < 8; b++) begin
			m[b] = st[6];
			st   = lfsr_next(st);
		end
		return m;
	endfunction

endpackage

/* rtl/ble_wcp_crc.sv */
// ----------------------------------------------------------------------------
// ble_wcp_crc
// CRC-16/CCITT over the command section of the message (bytes 11..22).
// ----------------------------------------------------------------------------
module ble_wcp_crc (
	input  ble_wcp_pkg::msg_t  msg,
	output logic [15:0]        crc
);
	import ble_wcp_pkg::*;

	logic [15:0] crc_acc;

	// unrolled byte updates reduce to a flat XOR network
	always_comb begin
		crc_acc = CRC_INIT;
		for (int i = 0; i < CRC_LEN; i++) begin
			crc_acc = crc16_byte(crc_acc, msg[CRC_FIRST + i]);
		end
	end

	assign crc = crc_acc;

endmodule

/* rtl/ble_wcp_frame.sv */
// ----------------------------------------------------------------------------
// ble_wcp_frame
// Insert the CRC, bit-reverse and whiten each message byte, add header and
// trailer to form the 32-byte packet.
// ----------------------------------------------------------------------------
module ble_wcp_frame (
	input  ble_wcp_pkg::msg_t  msg,
	input  logic [15:0]        crc,
	output ble_wcp_pkg::pkt_t  pkt
);
	import ble_wcp_pkg::*;

	msg_t full_msg;

	always_comb begin
		for (int i = 0; i < MSG_LEN; i++) begin
			full_msg[i] = msg[i];
		end
		full_msg[MSG_CRC_HI] = crc[15:8];
		full_msg[MSG_CRC_LO] = crc[7:0];
	end

	for (genvar h = 0; h < HDR_LEN; h++) begin : g_hdr
		assign pkt[h] = PKT_HEADER[h];
	end

	// whitening stream is fixed per position, folded to constants
	for (genvar i = 0; i < MSG_LEN; i++) begin : g_body
		localparam logic [7:0] WMASK = whiten_byte(i);
		assign pkt[MSG_OFS + i] = reverse8(full_msg[i]) ^ WMASK;
	end

	assign pkt[TRAILER_POS] = PKT_TRAILER;

endmodule

/* rtl/ble_whitened_command_packet.sv */
// ----------------------------------------------------------------------------
// ble_whitened_command_packet
// Lamp command packet encoder: builds the message, CRC and whitened packet.
// ----------------------------------------------------------------------------
// Timing: done is registered alongside the result register from the input register's valid flag.
// Throughput: one command per cycle; busy is held low, so start is always taken.
// Input register feeds CRC and whitening logic, result lands in the output register.
// Reset clears the valid flags and sets the group nibble to 1; payload registers are not reset.
// Each packet is shown for exactly one cycle with done; the receiver cannot stall.
module ble_whitened_command_packet (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ble_wcp_pkg::ADDR_W-1:0]    paddr,
	input  logic [ble_wcp_pkg::DATA_W-1:0]    pwdata,
	output logic [ble_wcp_pkg::DATA_W-1:0]    prdata,
	output logic                              pready,
	// command
	input  logic                              start,
	output logic                              busy,
	input  logic [7:0]                        command,
	input  logic [7:0]                        host_id_high,
	input  logic [7:0]                        host_id_low,
	input  logic [7:0]                        argument_one,
	input  logic [7:0]                        argument_two,
	input  logic [7:0]                        nonce_byte,
	// result
	output logic                              done,
	output logic [63:0]                       packet_word0,
	output logic [63:0]                       packet_word1,
	output logic [63:0]                       packet_word2,
	output logic [63:0]                       packet_word3
);
	import ble_wcp_pkg::*;

	logic               cfg_wr;
	logic               cfg_sel_group;
	logic [GROUP_W-1:0] grp_nib_q;

	logic               accept;
	logic               valid_s1;
	logic [7:0]         command_s1;
	logic [7:0]         host_hi_s1;
	logic [3:0]         host_lo_nib_s1;
	logic [7:0]         arg1_s1;
	logic [7:0]         arg2_s1;
	logic [7:0]         nonce_s1;

	msg_t               msg;
	logic [15:0]        crc;
	pkt_t               pkt;
	logic [63:0]        words [NUM_WORDS];

	logic               done_s2;
	logic [63:0]        words_s2 [NUM_WORDS];

	// configuration port
	assign pready        = 1'b1;
	assign cfg_sel_group = (paddr[ADDR_W-1] == REG_IDX_GROUP);
	assign cfg_wr        = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_nib_q <= GRP_NIB_RESET;
		end else if (cfg_wr && cfg_sel_group) begin
			grp_nib_q <= pwdata[GROUP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (cfg_sel_group) begin
			prdata = {{(DATA_W-GROUP_W){1'b0}}, grp_nib_q};
		end
	end

	// input register
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1     <= command;
			host_hi_s1     <= host_id_high;
			host_lo_nib_s1 <= host_id_low[7:4];
			arg1_s1        <= argument_one;
			arg2_s1        <= argument_two;
			nonce_s1       <= nonce_byte;
		end
	end

	// fill the message template
	always_comb begin
		for (int i = 0; i < MSG_LEN; i++) begin
			msg[i] = MSG_TEMPLATE[i];
		end
		msg[MSG_CMD]     = command_s1;
		msg[MSG_HOST_HI] = host_hi_s1;
		msg[MSG_HOST_LO] = {host_lo_nib_s1, grp_nib_q};
		msg[MSG_ARG1]    = arg1_s1;
		msg[MSG_ARG2]    = arg2_s1;
		msg[MSG_NONCE]   = nonce_s1;
	end

	ble_wcp_crc u_crc (
		.msg (msg),
		.crc (crc)
	);

	ble_wcp_frame u_frame (
		.msg (msg),
		.crc (crc),
		.pkt (pkt)
	);

	// pack bytes, lowest-numbered byte in the top position
	always_comb begin
		for (int w = 0; w < NUM_WORDS; w++) begin
			for (int b = 0; b < WORD_BYTES; b++) begin
				words[w][63-8*b -: 8] = pkt[WORD_BYTES*w + b];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int w = 0; w < NUM_WORDS; w++) begin
				words_s2[w] <= words[w];
			end
		end
	end

	assign done         = done_s2;
	assign packet_word0 = words_s2[0];
	assign packet_word1 = words_s2[1];
	assign packet_word2 = words_s2[2];
	assign packet_word3 = words_s2[3];

	// each accepted command yields a transfer once it has passed the input and result registers
	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("accepted command produced no packet");

	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("packet without a command in flight");

	a_group_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && cfg_sel_group) |=> (grp_nib_q == $past(pwdata[GROUP_W-1:0])))
		else $error("group nibble write lost");

	a_header: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (packet_word0[63:16] == PKT_HEADER_BITS))
		else $error("packet header corrupted");

	a_trailer: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (packet_word3[7:0] == PKT_TRAILER))
		else $error("packet trailer corrupted");

endmodule
